[hw/rtl/bounded_double_linked_list_unit_defines.svh]
// Assertion macros used by the checker file of the list unit.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef BOUNDED_DOUBLE_LINKED_LIST_UNIT_DEFINES_SVH
`define BOUNDED_DOUBLE_LINKED_LIST_UNIT_DEFINES_SVH

// Property that must hold at every edge out of reset
`define BDL_ASSERT_NOW(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("bdl checker: property violated");

// Antecedent this edge, consequent at the next edge
`define BDL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bdl checker: sequence violated");

`endif

[hw/rtl/bdl_pkg.sv]
// Shared types and constants for the bounded doubly linked list unit.
// No dependencies; the other RTL files that use it refer to it by scoped names.
`default_nettype none

package bdl_pkg;

  localparam int CAPACITY   = 64;
  localparam int KEY_WIDTH  = 32;
  localparam int SLOT_W     = $clog2(CAPACITY);
  localparam int CNT_W      = SLOT_W + 1;
  localparam int FIFO_DEPTH = 2;

  typedef enum logic [3:0] {
    CMD_PUSH_FRONT = 4'd0,
    CMD_PUSH_BACK  = 4'd1,
    CMD_POP_FRONT  = 4'd2,
    CMD_POP_BACK   = 4'd3,
    CMD_FIND       = 4'd4,
    CMD_ERASE      = 4'd5,
    CMD_REMOVE_ALL = 4'd6,
    CMD_INSERT     = 4'd7,
    CMD_CLEAR      = 4'd8,
    CMD_PALINDROME = 4'd9,
    CMD_NOP        = 4'd15
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // Classified command waiting between front and back
  typedef struct packed {
    cmd_t                 cmd;
    logic [KEY_WIDTH-1:0] key;
    logic [KEY_WIDTH-1:0] value;
  } job_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LINK,
    S_LINK_MID,
    S_POP_DEL,
    S_WALK_RD,
    S_WALK_CHK,
    S_PAL_RDR,
    S_PAL_CHK
  } state_t;

endpackage

`default_nettype wire

[hw/rtl/bdl_if.sv]
// Channel interfaces of the list unit: command beats in, result beats out.
// Depends on nothing; widths follow the fixed field widths.
`default_nettype none

interface bdl_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  cmd;
  logic [31:0] key;
  logic [31:0] new_value;

  modport source (output valid, cmd, key, new_value, input ready);
  modport sink   (input valid, cmd, key, new_value, output ready);
endinterface

interface bdl_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] popped_value;
  logic        found;
  logic [5:0]  position;
  logic [6:0]  removed_count;
  logic [6:0]  element_count;
  logic        is_palindrome;

  modport source (output valid, status, popped_value, found, position, removed_count,
                  element_count, is_palindrome, input ready);
  modport sink   (input valid, status, popped_value, found, position, removed_count,
                  element_count, is_palindrome, output ready);
endinterface

`default_nettype wire

[hw/rtl/bounded_double_linked_list_unit.sv]
// Bounded doubly linked list unit: a list of up to 64 signed 32-bit keys.
// Channels: in_ch carries one command beat (cmd, key, new_value); out_ch
// returns exactly one result beat per command, in command order. Both use
// valid/ready; a beat moves when both are high.
// Push and pop finish in the link or unlink state after the command beat;
// a refused or empty-list command finishes straight from idle; insert in
// the middle adds a second link state after the search. Find, erase and
// insert search 1 node per cycle from the front; remove_all and clear read
// and check the nodes in turn; palindrome compares one pair of nodes at a
// time. The walks go through the one read port of the node pool. A new
// command starts the cycle after the previous result beat is taken.
// A two-beat queue sits between the command decode and the list sequencer,
// so commands are taken while a result still waits at the output.
// Reset (rst_n low, synchronous) empties the list and restores the free
// stack; no clearing pass is needed. A stalled out_ch holds its beat and the
// sequencer waits; in_ch stalls once the queue fills.
// Depends on bdl_pkg, bdl_if, bdl_front, bdl_fifo and bdl_back.
`default_nettype none

module bounded_double_linked_list_unit (
  input  logic       clk,
  input  logic       rst_n,
  bdl_in_if.sink     in_ch,
  bdl_out_if.source  out_ch
);

  bdl_pkg::job_t fe_job, q_job;
  logic          fe_valid, fe_ready, q_valid, q_pop;

  bdl_front u_front (
    .in_ch     (in_ch),
    .job       (fe_job),
    .job_valid (fe_valid),
    .job_ready (fe_ready)
  );

  bdl_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_job   (fe_job),
    .wr_valid (fe_valid),
    .wr_ready (fe_ready),
    .rd_job   (q_job),
    .rd_valid (q_valid),
    .rd_pop   (q_pop)
  );

  bdl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (q_job),
    .job_valid (q_valid),
    .job_pop   (q_pop),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

[hw/rtl/bdl_front.sv]
// Front part: takes command beats and classifies them into jobs.
// Uses bdl_pkg and bdl_in_if; feeds the job queue.
`default_nettype none

module bdl_front (
  bdl_in_if.sink        in_ch,
  output bdl_pkg::job_t job,
  output logic          job_valid,
  input  logic          job_ready
);

  bdl_pkg::cmd_t cmd_cls;

  // Map raw codes, folding unused ones onto a no-op
  always_comb begin
    case (in_ch.cmd)
      bdl_pkg::CMD_PUSH_FRONT: cmd_cls = bdl_pkg::CMD_PUSH_FRONT;
      bdl_pkg::CMD_PUSH_BACK:  cmd_cls = bdl_pkg::CMD_PUSH_BACK;
      bdl_pkg::CMD_POP_FRONT:  cmd_cls = bdl_pkg::CMD_POP_FRONT;
      bdl_pkg::CMD_POP_BACK:   cmd_cls = bdl_pkg::CMD_POP_BACK;
      bdl_pkg::CMD_FIND:       cmd_cls = bdl_pkg::CMD_FIND;
      bdl_pkg::CMD_ERASE:      cmd_cls = bdl_pkg::CMD_ERASE;
      bdl_pkg::CMD_REMOVE_ALL: cmd_cls = bdl_pkg::CMD_REMOVE_ALL;
      bdl_pkg::CMD_INSERT:     cmd_cls = bdl_pkg::CMD_INSERT;
      bdl_pkg::CMD_CLEAR:      cmd_cls = bdl_pkg::CMD_CLEAR;
      bdl_pkg::CMD_PALINDROME: cmd_cls = bdl_pkg::CMD_PALINDROME;
      default:                 cmd_cls = bdl_pkg::CMD_NOP;
    endcase
  end

  assign job.cmd     = cmd_cls;
  assign job.key     = in_ch.key[bdl_pkg::KEY_WIDTH-1:0];
  assign job.value   = in_ch.new_value[bdl_pkg::KEY_WIDTH-1:0];
  assign job_valid   = in_ch.valid;
  assign in_ch.ready = job_ready;

endmodule

`default_nettype wire

[hw/rtl/bdl_fifo.sv]
// Short job queue between front and back so each side stalls on its own.
// Uses bdl_pkg for the job type and depth.
`default_nettype none

module bdl_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  bdl_pkg::job_t wr_job,
  input  logic          wr_valid,
  output logic          wr_ready,
  output bdl_pkg::job_t rd_job,
  output logic          rd_valid,
  input  logic          rd_pop
);

  localparam int PTR_W = $clog2(bdl_pkg::FIFO_DEPTH);
  localparam int CNT_W = $clog2(bdl_pkg::FIFO_DEPTH + 1);

  bdl_pkg::job_t    mem_r [bdl_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign wr_ready = cnt_r != CNT_W'(bdl_pkg::FIFO_DEPTH);
  assign rd_valid = cnt_r != '0;
  assign rd_job   = mem_r[rd_ptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_pop && rd_valid;

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(bdl_pkg::FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(bdl_pkg::FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + CNT_W'(do_wr) - CNT_W'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the incoming beat
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/bdl_back.sv]
// Back part: node pool memories, free stack and the list sequencer.
// Uses bdl_pkg and bdl_out_if; takes jobs from the queue.
`default_nettype none

module bdl_back (
  input  logic          clk,
  input  logic          rst_n,
  input  bdl_pkg::job_t job,
  input  logic          job_valid,
  output logic          job_pop,
  bdl_out_if.source     out_ch
);

  localparam int SW = bdl_pkg::SLOT_W;
  localparam int CW = bdl_pkg::CNT_W;
  localparam int KW = bdl_pkg::KEY_WIDTH;

  // Node pool and free stack
  logic [KW-1:0] key_mem  [bdl_pkg::CAPACITY];
  logic [SW-1:0] next_mem [bdl_pkg::CAPACITY];
  logic [SW-1:0] prev_mem [bdl_pkg::CAPACITY];
  logic [SW-1:0] free_mem [bdl_pkg::CAPACITY];
  logic [bdl_pkg::CAPACITY-1:0] free_vld_r;

  logic          key_we, next_we, prev_we, free_we;
  logic [SW-1:0] key_wa, next_wa, prev_wa, free_wa;
  logic [KW-1:0] key_wd;
  logic [SW-1:0] next_wd, prev_wd, free_wd;
  logic [SW-1:0] rd_addr, fr_addr;
  logic [KW-1:0] q_key_r;
  logic [SW-1:0] q_next_r, q_prev_r, free_q_r;

  // Control state
  bdl_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [SW-1:0]   head_r, head_nxt, tail_r, tail_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  // Work registers
  bdl_pkg::job_t   job_r, job_nxt;
  logic [SW-1:0]   cur_r, cur_nxt, lnext_r, lnext_nxt, rslot_r, rslot_nxt;
  logic [SW-1:0]   bef_r, bef_nxt, tslot_r, tslot_nxt;
  logic [CW-1:0]   idx_r, idx_nxt, n_r, n_nxt;
  logic [KW-1:0]   lkey_r, lkey_nxt;
  logic            front_r, front_nxt, mid_r, mid_nxt;

  // Result registers
  bdl_pkg::status_t status_r, status_nxt;
  logic [KW-1:0]    popped_r, popped_nxt;
  logic             found_r, found_nxt, pal_r, pal_nxt;
  logic [5:0]       pos_r, pos_nxt;
  logic [6:0]       removed_r, removed_nxt;

  logic          job_go, list_empty, list_full, chk_match, chk_last, pal_last, pal_eq;
  logic          fin, do_unlink;
  logic [CW-1:0] cnt_m1, idx_p1;
  logic [KW-1:0] push_val;
  logic [SW-1:0] walk_head;

  assign job_go     = (state_r == bdl_pkg::S_IDLE) && job_valid && !out_valid_r;
  assign list_empty = cnt_r == '0;
  assign list_full  = cnt_r == CW'(bdl_pkg::CAPACITY);
  assign cnt_m1     = cnt_r - 1'b1;
  assign idx_p1     = idx_r + 1'b1;
  assign chk_match  = (job_r.cmd == bdl_pkg::CMD_CLEAR) || (q_key_r == job_r.key);
  assign chk_last   = idx_p1 == n_r;
  assign pal_last   = idx_p1 == (cnt_r >> 1);
  assign pal_eq     = lkey_r == q_key_r;
  assign push_val   = (job_r.cmd == bdl_pkg::CMD_INSERT) ? job_r.value : job_r.key;
  assign walk_head  = head_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bdl_pkg::S_IDLE: begin
        if (job_go) begin
          case (job.cmd)
            bdl_pkg::CMD_PUSH_FRONT, bdl_pkg::CMD_PUSH_BACK: begin
              state_nxt = list_full ? bdl_pkg::S_IDLE : bdl_pkg::S_LINK;
            end
            bdl_pkg::CMD_POP_FRONT, bdl_pkg::CMD_POP_BACK: begin
              state_nxt = list_empty ? bdl_pkg::S_IDLE : bdl_pkg::S_POP_DEL;
            end
            bdl_pkg::CMD_FIND, bdl_pkg::CMD_ERASE, bdl_pkg::CMD_REMOVE_ALL,
            bdl_pkg::CMD_CLEAR: begin
              state_nxt = list_empty ? bdl_pkg::S_IDLE : bdl_pkg::S_WALK_CHK;
            end
            bdl_pkg::CMD_INSERT: begin
              if (list_full) state_nxt = bdl_pkg::S_IDLE;
              else if (list_empty) state_nxt = bdl_pkg::S_LINK;
              else state_nxt = bdl_pkg::S_WALK_CHK;
            end
            bdl_pkg::CMD_PALINDROME: begin
              state_nxt = (cnt_r <= CW'(1)) ? bdl_pkg::S_IDLE : bdl_pkg::S_PAL_RDR;
            end
            default: state_nxt = bdl_pkg::S_IDLE;
          endcase
        end
      end
      bdl_pkg::S_LINK:     state_nxt = mid_r ? bdl_pkg::S_LINK_MID : bdl_pkg::S_IDLE;
      bdl_pkg::S_LINK_MID: state_nxt = bdl_pkg::S_IDLE;
      bdl_pkg::S_POP_DEL:  state_nxt = bdl_pkg::S_IDLE;
      bdl_pkg::S_WALK_RD:  state_nxt = bdl_pkg::S_WALK_CHK;
      bdl_pkg::S_WALK_CHK: begin
        case (job_r.cmd)
          bdl_pkg::CMD_INSERT: begin
            if (chk_match) state_nxt = bdl_pkg::S_LINK;
            else if (chk_last) state_nxt = bdl_pkg::S_IDLE;
          end
          bdl_pkg::CMD_REMOVE_ALL, bdl_pkg::CMD_CLEAR: begin
            state_nxt = chk_last ? bdl_pkg::S_IDLE : bdl_pkg::S_WALK_RD;
          end
          default: begin
            if (chk_match || chk_last) state_nxt = bdl_pkg::S_IDLE;
          end
        endcase
      end
      bdl_pkg::S_PAL_RDR: state_nxt = bdl_pkg::S_PAL_CHK;
      bdl_pkg::S_PAL_CHK: begin
        state_nxt = (!pal_eq || pal_last) ? bdl_pkg::S_IDLE : bdl_pkg::S_PAL_RDR;
      end
      default: state_nxt = bdl_pkg::S_IDLE;
    endcase
  end

  // Datapath and memory controls per state
  always_comb begin
    job_nxt = job_r;  cur_nxt = cur_r;  lnext_nxt = lnext_r;  rslot_nxt = rslot_r;
    bef_nxt = bef_r;  tslot_nxt = tslot_r;  idx_nxt = idx_r;  n_nxt = n_r;
    lkey_nxt = lkey_r;  front_nxt = front_r;  mid_nxt = mid_r;
    head_nxt = head_r;  tail_nxt = tail_r;  cnt_nxt = cnt_r;
    status_nxt = status_r;  popped_nxt = popped_r;  found_nxt = found_r;
    pos_nxt = pos_r;  removed_nxt = removed_r;  pal_nxt = pal_r;
    key_we = 1'b0;  key_wa = '0;  key_wd = '0;
    next_we = 1'b0;  next_wa = '0;  next_wd = '0;
    prev_we = 1'b0;  prev_wa = '0;  prev_wd = '0;
    free_we = 1'b0;  free_wa = '0;  free_wd = '0;
    rd_addr = cur_r;
    fr_addr = cnt_r[SW-1:0];
    job_pop = 1'b0;
    fin = 1'b0;
    do_unlink = 1'b0;

    case (state_r)
      bdl_pkg::S_IDLE: begin
        if (job_go) begin
          job_pop = 1'b1;
          job_nxt = job;
          status_nxt = bdl_pkg::ST_OK;
          popped_nxt = '0;  found_nxt = 1'b0;  pos_nxt = '0;
          removed_nxt = '0;  pal_nxt = 1'b0;
          mid_nxt = 1'b0;
          front_nxt = job.cmd != bdl_pkg::CMD_PUSH_BACK;
          idx_nxt = '0;
          n_nxt = cnt_r;
          cur_nxt = walk_head;
          rd_addr = walk_head;
          case (job.cmd)
            bdl_pkg::CMD_PUSH_FRONT, bdl_pkg::CMD_PUSH_BACK: begin
              if (list_full) begin
                status_nxt = bdl_pkg::ST_FULL;
                fin = 1'b1;
              end
            end
            bdl_pkg::CMD_POP_FRONT, bdl_pkg::CMD_POP_BACK: begin
              if (list_empty) begin
                status_nxt = bdl_pkg::ST_EMPTY;
                fin = 1'b1;
              end else if (job.cmd == bdl_pkg::CMD_POP_BACK) begin
                cur_nxt = tail_r;
                rd_addr = tail_r;
              end
            end
            bdl_pkg::CMD_FIND, bdl_pkg::CMD_ERASE: begin
              if (list_empty) begin
                status_nxt = bdl_pkg::ST_NOT_FOUND;
                fin = 1'b1;
              end
            end
            bdl_pkg::CMD_REMOVE_ALL, bdl_pkg::CMD_CLEAR: begin
              if (list_empty) fin = 1'b1;
            end
            bdl_pkg::CMD_INSERT: begin
              if (list_full) begin
                status_nxt = bdl_pkg::ST_FULL;
                fin = 1'b1;
              end
            end
            bdl_pkg::CMD_PALINDROME: begin
              rslot_nxt = tail_r;
              if (cnt_r <= CW'(1)) begin
                pal_nxt = !list_empty;
                fin = 1'b1;
              end
            end
            default: fin = 1'b1;
          endcase
        end
      end

      // Take a free slot and link it in
      bdl_pkg::S_LINK: begin
        key_we = 1'b1;  key_wa = free_q_r;  key_wd = push_val;
        cnt_nxt = cnt_r + 1'b1;
        tslot_nxt = free_q_r;
        if (mid_r) begin
          prev_we = 1'b1;  prev_wa = free_q_r;  prev_wd = bef_r;
          next_we = 1'b1;  next_wa = free_q_r;  next_wd = cur_r;
        end else begin
          fin = 1'b1;
          if (list_empty) begin
            head_nxt = free_q_r;
            tail_nxt = free_q_r;
          end else if (front_r) begin
            next_we = 1'b1;  next_wa = free_q_r;  next_wd = head_r;
            prev_we = 1'b1;  prev_wa = head_r;    prev_wd = free_q_r;
            head_nxt = free_q_r;
          end else begin
            prev_we = 1'b1;  prev_wa = free_q_r;  prev_wd = tail_r;
            next_we = 1'b1;  next_wa = tail_r;    next_wd = free_q_r;
            tail_nxt = free_q_r;
          end
        end
      end

      // Close the links around the new middle node
      bdl_pkg::S_LINK_MID: begin
        next_we = 1'b1;  next_wa = bef_r;  next_wd = tslot_r;
        prev_we = 1'b1;  prev_wa = cur_r;  prev_wd = tslot_r;
        fin = 1'b1;
      end

      bdl_pkg::S_POP_DEL: begin
        popped_nxt = q_key_r;
        do_unlink = 1'b1;
        fin = 1'b1;
      end

      bdl_pkg::S_WALK_RD: begin
        rd_addr = cur_r;
      end

      // Compare the node just read and decide
      bdl_pkg::S_WALK_CHK: begin
        case (job_r.cmd)
          bdl_pkg::CMD_REMOVE_ALL, bdl_pkg::CMD_CLEAR: begin
            if (chk_match) begin
              do_unlink = 1'b1;
              removed_nxt = removed_r + 1'b1;
            end
            if (chk_last) begin
              fin = 1'b1;
            end else begin
              cur_nxt = q_next_r;
              idx_nxt = idx_p1;
            end
          end
          default: begin
            if (chk_match) begin
              if (job_r.cmd == bdl_pkg::CMD_INSERT) begin
                front_nxt = cur_r == head_r;
                mid_nxt = cur_r != head_r;
                bef_nxt = q_prev_r;
              end else begin
                found_nxt = 1'b1;
                pos_nxt = idx_r[5:0];
                do_unlink = job_r.cmd == bdl_pkg::CMD_ERASE;
                fin = 1'b1;
              end
            end else if (chk_last) begin
              status_nxt = bdl_pkg::ST_NOT_FOUND;
              fin = 1'b1;
            end else begin
              rd_addr = q_next_r;
              cur_nxt = q_next_r;
              idx_nxt = idx_p1;
            end
          end
        endcase
      end

      bdl_pkg::S_PAL_RDR: begin
        lkey_nxt = q_key_r;
        lnext_nxt = q_next_r;
        rd_addr = rslot_r;
      end

      bdl_pkg::S_PAL_CHK: begin
        if (!pal_eq) begin
          fin = 1'b1;
        end else if (pal_last) begin
          pal_nxt = 1'b1;
          fin = 1'b1;
        end else begin
          rd_addr = lnext_r;
          rslot_nxt = q_prev_r;
          idx_nxt = idx_p1;
        end
      end

      default: begin
      end
    endcase

    // Unlink the node at cur_r using the links just read
    if (do_unlink) begin
      if (cur_r == head_r) begin
        head_nxt = q_next_r;
      end else begin
        next_we = 1'b1;  next_wa = q_prev_r;  next_wd = q_next_r;
      end
      if (cur_r == tail_r) begin
        tail_nxt = q_prev_r;
      end else begin
        prev_we = 1'b1;  prev_wa = q_next_r;  prev_wd = q_prev_r;
      end
      cnt_nxt = cnt_m1;
      free_we = 1'b1;  free_wa = cnt_m1[SW-1:0];  free_wd = cur_r;
    end

    // Hold the result until the beat is taken
    out_valid_nxt = out_valid_r;
    if (out_ch.valid && out_ch.ready) out_valid_nxt = 1'b0;
    if (fin) out_valid_nxt = 1'b1;
  end

  // Memories with registered read data
  always_ff @(posedge clk) begin
    if (key_we)  key_mem[key_wa]   <= key_wd;
    if (next_we) next_mem[next_wa] <= next_wd;
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    if (free_we) free_mem[free_wa] <= free_wd;
    q_key_r  <= key_mem[rd_addr];
    q_next_r <= next_mem[rd_addr];
    q_prev_r <= prev_mem[rd_addr];
    free_q_r <= free_vld_r[fr_addr] ? free_mem[fr_addr] : fr_addr;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bdl_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= '0;
      free_vld_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      cnt_r       <= cnt_nxt;
      if (free_we) free_vld_r[free_wa] <= 1'b1;
    end
  end

  // Work and result registers
  always_ff @(posedge clk) begin
    job_r <= job_nxt;  cur_r <= cur_nxt;  lnext_r <= lnext_nxt;  rslot_r <= rslot_nxt;
    bef_r <= bef_nxt;  tslot_r <= tslot_nxt;  idx_r <= idx_nxt;  n_r <= n_nxt;
    lkey_r <= lkey_nxt;  front_r <= front_nxt;  mid_r <= mid_nxt;
    status_r <= status_nxt;  popped_r <= popped_nxt;  found_r <= found_nxt;
    pos_r <= pos_nxt;  removed_r <= removed_nxt;  pal_r <= pal_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = status_r;
  assign out_ch.popped_value  = 32'(signed'(popped_r));
  assign out_ch.found         = found_r;
  assign out_ch.position      = pos_r;
  assign out_ch.removed_count = removed_r;
  assign out_ch.element_count = 7'(cnt_r);
  assign out_ch.is_palindrome = pal_r;

endmodule

`default_nettype wire

[hw/rtl/bdl_checker.sv]
// Port-level checker for the list unit, bound to the top level.
// Uses bdl_pkg and the assertion macros header.
`default_nettype none
`include "bounded_double_linked_list_unit_defines.svh"

module bdl_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  status,
  input wire logic [31:0] popped_value,
  input wire logic        found,
  input wire logic [6:0]  element_count
);

  // A stalled result beat holds
  `BDL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(element_count))
  // Fill never exceeds the pool
  `BDL_ASSERT_NOW(a_cnt_bound, !out_valid || element_count <= 7'd64)
  // Full refusal only on a full list
  `BDL_ASSERT_NOW(a_full, !(out_valid && status == bdl_pkg::ST_FULL) || element_count == 7'd64)
  // Empty refusal only on an empty list, with nothing popped
  `BDL_ASSERT_NOW(a_empty, !(out_valid && status == bdl_pkg::ST_EMPTY) || (element_count == 7'd0 && popped_value == 32'd0))
  // A match always reports ok
  `BDL_ASSERT_NOW(a_found_ok, !(out_valid && found) || status == bdl_pkg::ST_OK)

endmodule

bind bounded_double_linked_list_unit bdl_checker u_bdl_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .status        (out_ch.status),
  .popped_value  (out_ch.popped_value),
  .found         (out_ch.found),
  .element_count (out_ch.element_count)
);

`default_nettype wire
